// ===== rtl/core/qte_pkg.sv =====
// Shared types and constants for the quaternion to Euler angle converter.
package qte_pkg;

    // CORDIC iteration count, capped at 32
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // Datapath widths: CORDIC vector, CORDIC angle (Q.30 radians)
    localparam int CW = 36;
    localparam int ZW = 34;

    // Square root iterations, one result bit per stage
    localparam int SQRT_STEPS = 32;

    // CORDIC lanes
    localparam int LANE_Y = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Z = 2;
    localparam int LANES  = 3;

    // Quarter turn in Q3.12
    localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;

    typedef enum logic [1:0] {
        CASE_GENERAL = 2'd0,
        CASE_NORTH   = 2'd1,
        CASE_SOUTH   = 2'd2,
        CASE_ZERO    = 2'd3
    } t_pole_case;

    // One atan2 argument pair
    typedef struct packed {
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] x;
    } t_vec;

    // Item moving through the square root pipeline
    typedef struct packed {
        t_pole_case  pcase;
        t_vec        arg_y;
        t_vec        arg_x;
        logic        neg;
        logic [31:0] ta;
        logic [63:0] rem;
        logic [63:0] root;
    } t_sq_item;

    // Item entering the CORDIC pipeline
    typedef struct packed {
        t_pole_case             pcase;
        t_vec [LANES-1:0]       arg;
    } t_cordic_in;

    // Item leaving the CORDIC pipeline
    typedef struct packed {
        t_pole_case                  pcase;
        logic [LANES-1:0][ZW-1:0]    ang;
    } t_angles;

endpackage

// ===== rtl/core/qte_front.sv =====
// Front end: products, sums, pole classification and radicand multiply.
module qte_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [15:0]   i_quat_w,
    input  logic signed [15:0]   i_quat_x,
    input  logic signed [15:0]   i_quat_y,
    input  logic signed [15:0]   i_quat_z,
    output logic                 o_valid,
    output qte_pkg::t_sq_item    o_item
);

    typedef struct packed {
        qte_pkg::t_pole_case pcase;
        qte_pkg::t_vec       arg_y;
        qte_pkg::t_vec       arg_x;
        logic                neg;
    } t_side;

    logic [4:0] r_vld;

    // stage 1: products
    logic signed [31:0] r_sw, r_sx, r_sy, r_sz, r_xy, r_zw, r_yw, r_xz, r_xw, r_yz;
    logic signed [15:0] r_x1, r_w1;
    // stage 2: sums
    logic signed [33:0] r_unit, r_test, r_gy, r_dy, r_gx, r_dx;
    logic signed [15:0] r_x2, r_w2;
    // stage 3: classification, scaled magnitudes
    t_side              r_side3, n_side3;
    logic [31:0]        r_u3, n_u3;
    logic [32:0]        r_ta3, n_ta3;
    // stage 4: clamp, difference and sum
    t_side              r_side4;
    logic [31:0]        r_diff4, r_ta4, w_ta_c;
    logic [32:0]        r_sum4;
    // stage 5: radicand
    t_side              r_side5;
    logic [31:0]        r_ta5;
    logic [63:0]        r_prod5;

    logic signed [43:0] w_tk, w_uk;
    logic signed [34:0] w_t2;
    logic [32:0]        w_ta_abs, w_unit_u;

    // advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    // stage 1: ten independent products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sw <= 32'(i_quat_w) * 32'(i_quat_w);
            r_sx <= 32'(i_quat_x) * 32'(i_quat_x);
            r_sy <= 32'(i_quat_y) * 32'(i_quat_y);
            r_sz <= 32'(i_quat_z) * 32'(i_quat_z);
            r_xy <= 32'(i_quat_x) * 32'(i_quat_y);
            r_zw <= 32'(i_quat_z) * 32'(i_quat_w);
            r_yw <= 32'(i_quat_y) * 32'(i_quat_w);
            r_xz <= 32'(i_quat_x) * 32'(i_quat_z);
            r_xw <= 32'(i_quat_x) * 32'(i_quat_w);
            r_yz <= 32'(i_quat_y) * 32'(i_quat_z);
            r_x1 <= i_quat_x;
            r_w1 <= i_quat_w;
        end
    end

    // stage 2: norm, test value and atan2 arguments
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_unit <= 34'(r_sw) + 34'(r_sx) + 34'(r_sy) + 34'(r_sz);
            r_test <= 34'(r_xy) + 34'(r_zw);
            r_gy   <= (34'(r_yw) - 34'(r_xz)) <<< 1;
            r_dy   <= 34'(r_sx) - 34'(r_sy) - 34'(r_sz) + 34'(r_sw);
            r_gx   <= (34'(r_xw) - 34'(r_yz)) <<< 1;
            r_dx   <= 34'(r_sy) - 34'(r_sx) - 34'(r_sz) + 34'(r_sw);
            r_x2   <= r_x1;
            r_w2   <= r_w1;
        end
    end

    // stage 3: pole tests, argument select, scale down large norms
    assign w_tk     = 44'(r_test) * 44'sd1000;
    assign w_uk     = 44'(r_unit) * 44'sd499;
    assign w_t2     = 35'(r_test) <<< 1;
    assign w_ta_abs = w_t2[34] ? 33'(-w_t2) : 33'(w_t2);
    assign w_unit_u = r_unit[32:0];

    always_comb begin
        n_side3.neg = w_t2[34];
        if (r_unit == '0) begin
            n_side3.pcase = qte_pkg::CASE_ZERO;
        end else if (w_tk > w_uk) begin
            n_side3.pcase = qte_pkg::CASE_NORTH;
        end else if (w_tk < -w_uk) begin
            n_side3.pcase = qte_pkg::CASE_SOUTH;
        end else begin
            n_side3.pcase = qte_pkg::CASE_GENERAL;
        end
        if (n_side3.pcase == qte_pkg::CASE_NORTH || n_side3.pcase == qte_pkg::CASE_SOUTH) begin
            n_side3.arg_y.y = qte_pkg::CW'(r_x2);
            n_side3.arg_y.x = qte_pkg::CW'(r_w2);
        end else begin
            n_side3.arg_y.y = qte_pkg::CW'(r_gy);
            n_side3.arg_y.x = qte_pkg::CW'(r_dy);
        end
        n_side3.arg_x.y = qte_pkg::CW'(r_gx);
        n_side3.arg_x.x = qte_pkg::CW'(r_dx);
        if (w_unit_u[32] | w_unit_u[31]) begin
            n_u3  = 32'(w_unit_u >> 1);
            n_ta3 = w_ta_abs >> 1;
        end else begin
            n_u3  = w_unit_u[31:0];
            n_ta3 = w_ta_abs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side3 <= n_side3;
            r_u3    <= n_u3;
            r_ta3   <= n_ta3;
        end
    end

    // stage 4: clamp test magnitude to the norm
    assign w_ta_c = (r_ta3 > {1'b0, r_u3}) ? r_u3 : r_ta3[31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side4 <= r_side3;
            r_ta4   <= w_ta_c;
            r_diff4 <= r_u3 - w_ta_c;
            r_sum4  <= {1'b0, r_u3} + {1'b0, w_ta_c};
        end
    end

    // stage 5: radicand (u - t) * (u + t)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side5 <= r_side4;
            r_ta5   <= r_ta4;
            r_prod5 <= 64'(r_diff4) * 64'(r_sum4);
        end
    end

    assign o_valid      = r_vld[4];
    assign o_item.pcase = r_side5.pcase;
    assign o_item.arg_y = r_side5.arg_y;
    assign o_item.arg_x = r_side5.arg_x;
    assign o_item.neg   = r_side5.neg;
    assign o_item.ta    = r_ta5;
    assign o_item.rem   = r_prod5;
    assign o_item.root  = '0;

endmodule

// ===== rtl/core/qte_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module qte_isqrt (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  qte_pkg::t_sq_item     i_item,
    output logic                  o_valid,
    output qte_pkg::t_cordic_in   o_item
);

    localparam int N = qte_pkg::SQRT_STEPS;

    logic              r_vld [N];
    qte_pkg::t_sq_item r_st  [N];

    logic                 [qte_pkg::CW-1:0] w_ta_ext;
    qte_pkg::t_sq_item    w_last;

    function automatic qte_pkg::t_sq_item sq_step(input qte_pkg::t_sq_item a,
                                                  input logic [63:0] sq_bit);
        qte_pkg::t_sq_item r;
        logic [63:0]       trial;
        r     = a;
        trial = a.root + sq_bit;
        if (a.rem >= trial) begin
            r.rem  = a.rem - trial;
            r.root = (a.root >> 1) + sq_bit;
        end else begin
            r.root = a.root >> 1;
        end
        return r;
    endfunction

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
        qte_pkg::t_sq_item w_prev;
        logic              w_vprev;

        if (k == 0) begin : g_first
            assign w_prev  = i_item;
            assign w_vprev = i_valid;
        end else begin : g_next
            assign w_prev  = r_st[k-1];
            assign w_vprev = r_vld[k-1];
        end

        // advance valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vprev;
            end
        end

        // try one result bit
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= sq_step(w_prev, SQ_BIT);
            end
        end
    end

    // assemble the three CORDIC lanes
    assign w_last   = r_st[N-1];
    assign w_ta_ext = {{(qte_pkg::CW-32){1'b0}}, w_last.ta};

    assign o_valid                           = r_vld[N-1];
    assign o_item.pcase                      = w_last.pcase;
    assign o_item.arg[qte_pkg::LANE_Y]       = w_last.arg_y;
    assign o_item.arg[qte_pkg::LANE_X]       = w_last.arg_x;
    assign o_item.arg[qte_pkg::LANE_Z].x     = {{(qte_pkg::CW-32){1'b0}}, w_last.root[31:0]};
    assign o_item.arg[qte_pkg::LANE_Z].y     = w_last.neg ? -w_ta_ext : w_ta_ext;

endmodule

// ===== rtl/core/qte_cordic.sv =====
// Three-lane pipelined CORDIC atan2 in vectoring mode.
module qte_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  qte_pkg::t_cordic_in   i_item,
    output logic                  o_valid,
    output qte_pkg::t_angles      o_item
);

    localparam int NS = qte_pkg::CORDIC_ITERS + 1;
    localparam logic signed [qte_pkg::ZW-1:0] PI_Q30 = 34'sd3373259426;

    typedef struct packed {
        logic                          zero;
        logic signed [qte_pkg::CW-1:0] x;
        logic signed [qte_pkg::CW-1:0] y;
        logic signed [qte_pkg::ZW-1:0] z;
    } t_rot;

    typedef struct packed {
        qte_pkg::t_pole_case          pcase;
        t_rot [qte_pkg::LANES-1:0]    lane;
    } t_rot_item;

    logic      r_vld [NS];
    t_rot_item r_st  [NS];
    t_rot_item w_last;

    // arctangent of 2^-i in Q.30
    function automatic logic signed [qte_pkg::ZW-1:0] atan_q30(input int i);
        logic [30:0] v;
        case (i)
            0:  v = 31'd843314856;
            1:  v = 31'd497837829;
            2:  v = 31'd263043836;
            3:  v = 31'd133525158;
            4:  v = 31'd67021686;
            5:  v = 31'd33543515;
            6:  v = 31'd16775850;
            7:  v = 31'd8388437;
            8:  v = 31'd4194282;
            9:  v = 31'd2097149;
            10: v = 31'd1048575;
            11: v = 31'd524287;
            12: v = 31'd262143;
            13: v = 31'd131071;
            14: v = 31'd65535;
            15: v = 31'd32767;
            16: v = 31'd16383;
            17: v = 31'd8191;
            18: v = 31'd4095;
            19: v = 31'd2047;
            20: v = 31'd1023;
            21: v = 31'd511;
            22: v = 31'd255;
            23: v = 31'd127;
            24: v = 31'd63;
            25: v = 31'd31;
            26: v = 31'd15;
            27: v = 31'd8;
            28: v = 31'd4;
            29: v = 31'd2;
            30: v = 31'd1;
            default: v = 31'd0;
        endcase
        return {{(qte_pkg::ZW-31){1'b0}}, v};
    endfunction

    // fold the left half plane onto the right
    function automatic t_rot pre_rot(input qte_pkg::t_vec v);
        t_rot r;
        r.zero = (v.x == '0) && (v.y == '0);
        if ($signed(v.x) < 0) begin
            r.z = ($signed(v.y) >= 0) ? PI_Q30 : -PI_Q30;
            r.x = -$signed(v.x);
            r.y = -$signed(v.y);
        end else begin
            r.z = '0;
            r.x = v.x;
            r.y = v.y;
        end
        return r;
    endfunction

    // one micro-rotation toward the x axis
    function automatic t_rot rot_step(input t_rot a, input int sh,
                                      input logic signed [qte_pkg::ZW-1:0] ang);
        t_rot r;
        r = a;
        if ($signed(a.y) > 0) begin
            r.x = $signed(a.x) + ($signed(a.y) >>> sh);
            r.y = $signed(a.y) - ($signed(a.x) >>> sh);
            r.z = $signed(a.z) + ang;
        end else begin
            r.x = $signed(a.x) - ($signed(a.y) >>> sh);
            r.y = $signed(a.y) + ($signed(a.x) >>> sh);
            r.z = $signed(a.z) - ang;
        end
        return r;
    endfunction

    for (genvar s = 0; s < NS; s++) begin : g_stage
        t_rot_item n_cur;
        logic      w_vprev;

        if (s == 0) begin : g_pre
            assign w_vprev = i_valid;
            always_comb begin
                n_cur.pcase = i_item.pcase;
                for (int l = 0; l < qte_pkg::LANES; l++) begin
                    n_cur.lane[l] = pre_rot(i_item.arg[l]);
                end
            end
        end else begin : g_iter
            assign w_vprev = r_vld[s-1];
            always_comb begin
                n_cur.pcase = r_st[s-1].pcase;
                for (int l = 0; l < qte_pkg::LANES; l++) begin
                    n_cur.lane[l] = rot_step(r_st[s-1].lane[l], s - 1, atan_q30(s - 1));
                end
            end
        end

        // advance valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vprev;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= n_cur;
            end
        end
    end

    // origin gives zero angle
    assign w_last = r_st[NS-1];

    always_comb begin
        o_item.pcase = w_last.pcase;
        for (int l = 0; l < qte_pkg::LANES; l++) begin
            o_item.ang[l] = w_last.lane[l].zero ? '0 : w_last.lane[l].z;
        end
    end

    assign o_valid = r_vld[NS-1];

endmodule

// ===== rtl/core/qte_out.sv =====
// Result formatting and two-entry output buffer; drives the pipeline enable.
module qte_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  qte_pkg::t_angles    i_item,
    input  logic                i_stall,
    output logic                o_en,
    output logic                o_valid,
    output logic signed [15:0]  o_angle_about_x,
    output logic signed [15:0]  o_angle_about_y,
    output logic signed [15:0]  o_angle_about_z,
    output logic [1:0]          o_pole_case
);

    localparam int AW = qte_pkg::ZW + 2;
    localparam logic signed [AW-1:0] RND     = AW'(32'sd131072);
    localparam logic signed [AW-1:0] Q12_MAX = AW'(32'sd32767);
    localparam logic signed [AW-1:0] Q12_MIN = AW'(-32'sd32768);

    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] az;
        logic [1:0]  pc;
    } t_result;

    t_result     r_ent [2];
    t_result     n_res;
    logic        r_wr, r_rd;
    logic [1:0]  r_count, n_count;
    logic        w_push, w_pop;

    logic signed [qte_pkg::ZW-1:0] w_za, w_zx, w_zz;
    logic signed [AW-1:0]          w_dbl;

    // round Q.30 to Q3.12 and saturate
    function automatic logic [15:0] to_q12(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] s;
        s = (a + RND) >>> 18;
        if (s > Q12_MAX) begin
            return 16'h7fff;
        end else if (s < Q12_MIN) begin
            return 16'h8000;
        end
        return s[15:0];
    endfunction

    assign w_za  = $signed(i_item.ang[qte_pkg::LANE_Y]);
    assign w_zx  = $signed(i_item.ang[qte_pkg::LANE_X]);
    assign w_zz  = $signed(i_item.ang[qte_pkg::LANE_Z]);
    assign w_dbl = AW'(w_za) <<< 1;

    // select angles by case
    always_comb begin
        n_res.pc = i_item.pcase;
        case (i_item.pcase)
            qte_pkg::CASE_NORTH: begin
                n_res.ax = '0;
                n_res.ay = to_q12(w_dbl);
                n_res.az = qte_pkg::HALF_PI_Q12;
            end
            qte_pkg::CASE_SOUTH: begin
                n_res.ax = '0;
                n_res.ay = to_q12(-w_dbl);
                n_res.az = -qte_pkg::HALF_PI_Q12;
            end
            qte_pkg::CASE_ZERO: begin
                n_res.ax = '0;
                n_res.ay = '0;
                n_res.az = '0;
            end
            default: begin
                n_res.ax = to_q12(AW'(w_zx));
                n_res.ay = to_q12(AW'(w_za));
                n_res.az = to_q12(AW'(w_zz));
            end
        endcase
    end

    // buffer control: pipeline runs while a slot is free
    assign o_en   = (r_count != 2'd2);
    assign w_push = i_valid && o_en;
    assign w_pop  = (r_count != 2'd0) && !i_stall;

    always_comb begin
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wr] <= n_res;
        end
    end

    assign o_valid         = (r_count != 2'd0);
    assign o_angle_about_x = r_ent[r_rd].ax;
    assign o_angle_about_y = r_ent[r_rd].ay;
    assign o_angle_about_z = r_ent[r_rd].az;
    assign o_pole_case     = r_ent[r_rd].pc;

endmodule

// ===== rtl/core/quaternion_to_euler_core.sv =====
// Quaternion to Euler angle converter with pole handling, top level.
// Pipeline: 5 front-end stages, 32 square-root stages, 17 CORDIC stages, then
//   a registered write into the output buffer.
// Throughput: one quaternion per cycle; a two-entry output buffer holds results
//   while the consumer stalls, and the whole pipeline holds when it is full.
// Reset: synchronous, active low; clears valid bits and the output buffer.
module quaternion_to_euler_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [15:0]  i_quat_w,
    input  logic signed [15:0]  i_quat_x,
    input  logic signed [15:0]  i_quat_y,
    input  logic signed [15:0]  i_quat_z,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_angle_about_x,
    output logic signed [15:0]  o_angle_about_y,
    output logic signed [15:0]  o_angle_about_z,
    output logic [1:0]          o_pole_case
);

    logic                 w_en;
    logic                 w_fe_valid, w_sq_valid, w_cd_valid;
    qte_pkg::t_sq_item    w_fe_item;
    qte_pkg::t_cordic_in  w_sq_item;
    qte_pkg::t_angles     w_cd_item;

    assign o_stall = !w_en;

    qte_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_valid),
        .i_quat_w (i_quat_w),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .o_valid  (w_fe_valid),
        .o_item   (w_fe_item)
    );

    qte_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fe_valid),
        .i_item  (w_fe_item),
        .o_valid (w_sq_valid),
        .o_item  (w_sq_item)
    );

    qte_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_valid),
        .i_item  (w_sq_item),
        .o_valid (w_cd_valid),
        .o_item  (w_cd_item)
    );

    qte_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_cd_valid),
        .i_item          (w_cd_item),
        .i_stall         (i_stall),
        .o_en            (w_en),
        .o_valid         (o_valid),
        .o_angle_about_x (o_angle_about_x),
        .o_angle_about_y (o_angle_about_y),
        .o_angle_about_z (o_angle_about_z),
        .o_pole_case     (o_pole_case)
    );

endmodule

// ===== rtl/core/qte_checker.sv =====
// Port-level checks for the quaternion to Euler converter, bound to the top level.
module qte_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic signed [15:0]  o_angle_about_x,
    input logic signed [15:0]  o_angle_about_y,
    input logic signed [15:0]  o_angle_about_z,
    input logic [1:0]          o_pole_case
);

    // no result and no input stall right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or input stalled after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_angle_about_x)
            && $stable(o_angle_about_y) && $stable(o_angle_about_z)
            && $stable(o_pole_case))
        else $error("stalled result changed");

    // zero quaternion gives zero angles
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pole_case == qte_pkg::CASE_ZERO |->
            o_angle_about_x == 16'sd0 && o_angle_about_y == 16'sd0
            && o_angle_about_z == 16'sd0)
        else $error("zero quaternion with nonzero angle");

    // north pole pins x and z
    a_north: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pole_case == qte_pkg::CASE_NORTH |->
            o_angle_about_x == 16'sd0 && o_angle_about_z == qte_pkg::HALF_PI_Q12)
        else $error("north pole angles wrong");

    // south pole pins x and z
    a_south: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pole_case == qte_pkg::CASE_SOUTH |->
            o_angle_about_x == 16'sd0 && o_angle_about_z == -qte_pkg::HALF_PI_Q12)
        else $error("south pole angles wrong");

endmodule

bind quaternion_to_euler_core qte_checker u_qte_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_angle_about_x (o_angle_about_x),
    .o_angle_about_y (o_angle_about_y),
    .o_angle_about_z (o_angle_about_z),
    .o_pole_case     (o_pole_case)
);
